[rtl/rur_pkg.sv]
// Shared types and constants for the reliable UDP receive reorder block.
// Used by rur_alu and reliable_udp_receive_reorder; no dependencies.
package rur_pkg;

   localparam int SeqW = 32;
   localparam int HandleW = 13;
   localparam int LenW = 16;
   localparam int MacW = 48;
   localparam int PortW = 16;
   localparam int MaxResults = 10;

   localparam logic [15:0] EtherIpv4 = 16'h0800;
   localparam logic [7:0] ProtoUdp = 8'd17;
   localparam logic [15:0] ListenPortReset = 16'd12346;
   localparam logic [15:0] WindowReset = 16'd64;

   localparam logic [15:0] FlagData = 16'h0001;
   localparam logic [15:0] FlagAck = 16'h0002;
   localparam logic [15:0] FlagSyn = 16'h0004;
   localparam logic [15:0] FlagFin = 16'h0008;

   localparam logic [0:0] CsrListenPort = 1'b0;
   localparam logic [0:0] CsrWindow = 1'b1;

   typedef enum logic [1:0] {
      KIND_ACK = 2'd0,
      KIND_DELIVER = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_REFUSE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [HandleW-1:0] handle;
      logic [SeqW-1:0] ack_number;
      logic [3:0] ack_flags;
      logic [15:0] ack_window;
      logic [31:0] peer_ip;
      logic [PortW-1:0] peer_port;
      logic [MacW-1:0] peer_mac;
   } result_type;

   typedef struct packed {
      logic [15:0] eth_type;
      logic [7:0] ip_protocol;
      logic [31:0] source_ip;
      logic [PortW-1:0] source_port;
      logic [PortW-1:0] dest_port;
      logic [MacW-1:0] source_mac;
      logic [SeqW-1:0] seq_number;
      logic [15:0] header_flags;
      logic [LenW-1:0] payload_length;
      logic [HandleW-1:0] buffer_handle;
   } request_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [PortW-1:0] port;
      logic [MacW-1:0] mac;
      logic [SeqW-1:0] expected;
      logic [SeqW-1:0] last_acked;
   } conn_type;

   typedef struct packed {
      logic [SeqW-1:0] seq;
      logic [LenW-1:0] length;
      logic [HandleW-1:0] handle;
   } slot_type;

   typedef struct packed {
      logic [SeqW-1:0] sum;
      logic eq;
      logic lt;
   } alu_result_type;

   typedef enum logic [23:0] {
      ST_IDLE  = 24'h000001,
      ST_CHK   = 24'h000002,
      ST_CRD   = 24'h000004,
      ST_CEV   = 24'h000008,
      ST_CNEW  = 24'h000010,
      ST_CLOAD = 24'h000020,
      ST_DISP  = 24'h000040,
      ST_DADD  = 24'h000080,
      ST_SRD   = 24'h000100,
      ST_SCMP1 = 24'h000200,
      ST_SCMP2 = 24'h000400,
      ST_SDONE = 24'h000800,
      ST_PRD   = 24'h001000,
      ST_PROC  = 24'h002000,
      ST_PADD  = 24'h004000,
      ST_HRD   = 24'h008000,
      ST_HEV   = 24'h010000,
      ST_HDONE = 24'h020000,
      ST_HSR   = 24'h040000,
      ST_HSAME = 24'h080000,
      ST_ACK   = 24'h100000,
      ST_EREL  = 24'h200000,
      ST_WB    = 24'h400000,
      ST_FLUSH = 24'h800000
   } state_type;

endpackage

[rtl/rur_alu.sv]
// Shared 32-bit add and compare unit used by the sequencer for every
// sequence step. Depends on rur_pkg.
module rur_alu
   import rur_pkg::*;
(
   input  logic [SeqW-1:0] op_a,
   input  logic [SeqW-1:0] op_b,
   output alu_result_type  res
);
   always_comb begin
      res.sum = op_a + op_b;
      res.eq = (op_a == op_b);
      res.lt = (op_a < op_b);
   end
endmodule

[rtl/reliable_udp_receive_reorder.sv]
// Top level: connection table, reorder slot store and the sequencer.
// Depends on rur_pkg and rur_alu.
//
//  channel | ports                  | transfer
//  --------+------------------------+----------------------------------
//  request | start, busy, req_*     | edge with start high, busy low
//  result  | rsp_valid, rsp_*       | every cycle rsp_valid is high
//  config  | csr_write_en, csr_*    | every edge with csr_write_en high
//
// A frame that passes the checks gets a table search over all CONN_ENTRIES
// entries, then where needed the in-order slot scans, which are paced by
// the single shared add/compare unit and the registered-read slot memory.
// Each result is held one step and leaves at the edge that makes the next
// one; the last leaves at the flush edge with rsp_last set. Reset is
// synchronous and clears the valid bits at once.
// The receiver cannot stall; busy falls as the last result is presented.
module reliable_udp_receive_reorder
   import rur_pkg::*;
#(
   parameter int CONN_ENTRIES = 16,
   parameter int REORDER_SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [15:0]         req_eth_type,
   input  logic [7:0]          req_ip_protocol,
   input  logic [31:0]         req_source_ip,
   input  logic [15:0]         req_source_port,
   input  logic [15:0]         req_dest_port,
   input  logic [47:0]         req_source_mac,
   input  logic [31:0]         req_seq_number,
   input  logic [15:0]         req_header_flags,
   input  logic [15:0]         req_payload_length,
   input  logic [12:0]         req_buffer_handle,
   output logic                rsp_valid,
   output logic [1:0]          rsp_kind,
   output logic [12:0]         rsp_out_handle,
   output logic [31:0]         rsp_ack_number,
   output logic [3:0]          rsp_ack_flags,
   output logic [15:0]         rsp_ack_window,
   output logic [31:0]         rsp_peer_ip,
   output logic [15:0]         rsp_peer_port,
   output logic [47:0]         rsp_peer_mac,
   output logic                rsp_last,
   input  logic                csr_write_en,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_data
);
   localparam int CW = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
   localparam int RW = (REORDER_SLOTS > 1) ? $clog2(REORDER_SLOTS) : 1;
   localparam int SlotTotal = CONN_ENTRIES * REORDER_SLOTS;
   localparam int SAW = (SlotTotal > 1) ? $clog2(SlotTotal) : 1;
   localparam logic [CW-1:0] ConnLast = CW'(CONN_ENTRIES - 1);
   localparam logic [RW-1:0] SlotLast = RW'(REORDER_SLOTS - 1);

   state_type state_ff, state_in;
   request_type req_ff;
   logic [15:0] listen_port_ff, window_ff;

   logic [CONN_ENTRIES-1:0] conn_vld_ff, conn_open_ff;
   conn_type conn_mem [CONN_ENTRIES];
   conn_type conn_q_ff;
   logic [CW-1:0] conn_rd_addr;

   logic [SlotTotal-1:0] slot_vld_ff;
   slot_type slot_mem [SlotTotal];
   slot_type slot_q_ff;
   logic [SAW-1:0] slot_rd_addr, slot_wr_addr;
   logic slot_we;
   logic slot_cur_vld;

   logic [CW-1:0] ci_ff, c_ff, free_ff;
   logic found_ff, freef_ff;
   logic [SAW-1:0] base_ff, base_calc;
   logic [31:0] cip_ff;
   logic [15:0] cport_ff;
   logic [47:0] cmac_ff;
   logic [SeqW-1:0] exp_ff, last_ff;
   logic open_ff;

   logic [RW-1:0] k_ff, min_k_ff, same_k_ff, empty_k_ff;
   logic [SeqW-1:0] thr_ff, min_ff;
   logic have_thr_ff, have_min_ff, same_f_ff, empty_f_ff, mode_fin_ff;

   logic [SeqW-1:0] alu_a, alu_b;
   alu_result_type alu;

   logic res_vld;
   result_type res;
   logic pend_vld_ff;
   result_type pend_ff;
   logic [3:0] prod_cnt_ff;
   logic accept;

   logic is_syn, is_fin, is_data, frame_ok;
   logic conn_hit;

   rur_alu u_alu (.op_a(alu_a), .op_b(alu_b), .res(alu));

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign is_syn = (req_ff.header_flags & FlagSyn) != 16'd0;
   assign is_fin = (req_ff.header_flags & FlagFin) != 16'd0;
   assign is_data = (req_ff.header_flags & FlagData) != 16'd0;
   assign frame_ok = (req_ff.eth_type == EtherIpv4) && (req_ff.ip_protocol == ProtoUdp)
                     && (req_ff.dest_port == listen_port_ff);
   assign conn_hit = conn_vld_ff[ci_ff] && (conn_q_ff.ip == req_ff.source_ip)
                     && (conn_q_ff.port == req_ff.source_port);
   assign base_calc = SAW'(found_ff ? c_ff : free_ff) * SAW'(REORDER_SLOTS);
   assign conn_rd_addr = (state_ff == ST_CNEW) ? c_ff : ci_ff;
   assign slot_rd_addr = base_ff + SAW'(k_ff);
   assign slot_wr_addr = base_ff + SAW'((state_ff == ST_HSAME) ? k_ff : empty_k_ff);
   assign slot_we = (state_ff == ST_HSAME) || (state_ff == ST_HDONE && !same_f_ff && empty_f_ff);
   assign slot_cur_vld = slot_vld_ff[slot_rd_addr];

   // shared unit operand select
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         ST_DISP: begin
            alu_a = req_ff.seq_number;
            alu_b = (is_syn || is_fin) ? SeqW'(1) : exp_ff;
         end
         ST_DADD: begin
            alu_a = exp_ff;
            alu_b = SeqW'(req_ff.payload_length);
         end
         ST_SCMP1: begin
            alu_a = thr_ff;
            alu_b = slot_q_ff.seq;
         end
         ST_SCMP2: begin
            alu_a = slot_q_ff.seq;
            alu_b = min_ff;
         end
         ST_PROC: begin
            alu_a = slot_q_ff.seq;
            alu_b = exp_ff;
         end
         ST_PADD: begin
            alu_a = exp_ff;
            alu_b = SeqW'(slot_q_ff.length);
         end
         ST_HEV: begin
            alu_a = slot_q_ff.seq;
            alu_b = req_ff.seq_number;
         end
         default: begin
         end
      endcase
   end

   function automatic result_type buf_res(kind_type kd, logic [HandleW-1:0] h);
      result_type r;
      r = '0;
      r.kind = kd;
      r.handle = h;
      return r;
   endfunction

   // sequencer next state and result generation
   always_comb begin
      result_type ack_r;
      ack_r = '0;
      ack_r.kind = KIND_ACK;
      ack_r.ack_number = last_ff;
      ack_r.ack_flags = FlagAck[3:0];
      ack_r.ack_window = window_ff;
      ack_r.peer_ip = cip_ff;
      ack_r.peer_port = cport_ff;
      ack_r.peer_mac = cmac_ff;
      state_in = state_ff;
      res_vld = 1'b0;
      res = '0;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_CHK;
         ST_CHK: begin
            if (!frame_ok) begin
               res_vld = 1'b1;
               res = buf_res(KIND_RELEASE, req_ff.buffer_handle);
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_CRD;
            end
         end
         ST_CRD: state_in = ST_CEV;
         ST_CEV: state_in = (ci_ff == ConnLast) ? ST_CNEW : ST_CRD;
         ST_CNEW: begin
            if (found_ff) begin
               state_in = ST_CLOAD;
            end else if (freef_ff) begin
               state_in = ST_DISP;
            end else begin
               res_vld = 1'b1;
               res = buf_res(KIND_REFUSE, req_ff.buffer_handle);
               state_in = ST_FLUSH;
            end
         end
         ST_CLOAD: state_in = ST_DISP;
         ST_DISP: begin
            res_vld = 1'b1;
            if (is_syn) begin
               res = ack_r;
               res.ack_number = alu.sum;
               res.ack_flags = FlagSyn[3:0] | FlagAck[3:0];
               state_in = ST_EREL;
            end else if (is_fin) begin
               res = ack_r;
               res.ack_number = alu.sum;
               res.ack_flags = FlagFin[3:0] | FlagAck[3:0];
               res.ack_window = '0;
               state_in = ST_SRD;
            end else if (is_data) begin
               if (alu.eq) begin
                  res = buf_res(KIND_DELIVER, req_ff.buffer_handle);
                  state_in = ST_DADD;
               end else if (alu.lt) begin
                  res = ack_r;
                  state_in = ST_EREL;
               end else begin
                  res_vld = 1'b0;
                  state_in = ST_HRD;
               end
            end else begin
               res = buf_res(KIND_RELEASE, req_ff.buffer_handle);
               state_in = ST_WB;
            end
         end
         ST_DADD: state_in = ST_SRD;
         ST_SRD: state_in = ST_SCMP1;
         ST_SCMP1: begin
            if (slot_cur_vld && (!have_thr_ff || alu.lt)) state_in = ST_SCMP2;
            else state_in = (k_ff == SlotLast) ? ST_SDONE : ST_SRD;
         end
         ST_SCMP2: state_in = (k_ff == SlotLast) ? ST_SDONE : ST_SRD;
         ST_SDONE: begin
            if (have_min_ff) state_in = ST_PRD;
            else state_in = mode_fin_ff ? ST_EREL : ST_ACK;
         end
         ST_PRD: state_in = ST_PROC;
         ST_PROC: begin
            state_in = ST_SRD;
            if (mode_fin_ff || (!alu.eq && alu.lt)) begin
               res_vld = 1'b1;
               res = buf_res(KIND_RELEASE, slot_q_ff.handle);
            end else if (alu.eq) begin
               res_vld = 1'b1;
               res = buf_res(KIND_DELIVER, slot_q_ff.handle);
               state_in = ST_PADD;
            end
         end
         ST_PADD: state_in = ST_SRD;
         ST_HRD: state_in = ST_HEV;
         ST_HEV: state_in = (k_ff == SlotLast) ? ST_HDONE : ST_HRD;
         ST_HDONE: begin
            if (same_f_ff) begin
               state_in = ST_HSR;
            end else begin
               state_in = ST_ACK;
               if (!empty_f_ff) begin
                  res_vld = 1'b1;
                  res = buf_res(KIND_RELEASE, req_ff.buffer_handle);
               end
            end
         end
         ST_HSR: state_in = ST_HSAME;
         ST_HSAME: begin
            res_vld = 1'b1;
            res = buf_res(KIND_RELEASE, slot_q_ff.handle);
            state_in = ST_ACK;
         end
         ST_ACK: begin
            res_vld = 1'b1;
            res = ack_r;
            state_in = ST_WB;
         end
         ST_EREL: begin
            res_vld = 1'b1;
            res = buf_res(KIND_RELEASE, req_ff.buffer_handle);
            state_in = ST_WB;
         end
         ST_WB: state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      conn_q_ff <= conn_mem[conn_rd_addr];
      if (state_ff == ST_WB) begin
         conn_mem[c_ff] <= '{ip: cip_ff, port: cport_ff, mac: cmac_ff,
                             expected: exp_ff, last_acked: last_ff};
      end
   end

   always_ff @(posedge clock) begin
      slot_q_ff <= slot_mem[slot_rd_addr];
      if (slot_we) begin
         slot_mem[slot_wr_addr] <= '{seq: req_ff.seq_number, length: req_ff.payload_length,
                                     handle: req_ff.buffer_handle};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         listen_port_ff <= ListenPortReset;
         window_ff <= WindowReset;
         conn_vld_ff <= '0;
         conn_open_ff <= '0;
         slot_vld_ff <= '0;
         pend_vld_ff <= 1'b0;
         prod_cnt_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= 1'b0;
         if (csr_write_en) begin
            if (csr_index == CsrListenPort) listen_port_ff <= csr_data;
            if (csr_index == CsrWindow) window_ff <= csr_data;
         end
         if (accept) prod_cnt_ff <= '0;
         if (res_vld && prod_cnt_ff < 4'(MaxResults)) begin
            prod_cnt_ff <= prod_cnt_ff + 4'd1;
            pend_vld_ff <= 1'b1;
            if (pend_vld_ff) rsp_valid <= 1'b1;
         end
         if (state_ff == ST_FLUSH) begin
            pend_vld_ff <= 1'b0;
            rsp_valid <= pend_vld_ff;
         end
         if (state_ff == ST_CNEW && !found_ff && freef_ff) begin
            conn_vld_ff[free_ff] <= 1'b1;
            for (int i = 0; i < REORDER_SLOTS; i++) begin
               slot_vld_ff[base_calc + SAW'(i)] <= 1'b0;
            end
         end
         if (state_ff == ST_WB) conn_open_ff[c_ff] <= open_ff;
         if (state_ff == ST_PROC && (mode_fin_ff || alu.eq || alu.lt)) begin
            slot_vld_ff[slot_rd_addr] <= 1'b0;
         end
         if (state_ff == ST_HDONE && !same_f_ff && empty_f_ff) begin
            slot_vld_ff[slot_wr_addr] <= 1'b1;
         end
      end
   end

   // result output registers
   always_ff @(posedge clock) begin
      if (res_vld && prod_cnt_ff < 4'(MaxResults)) pend_ff <= res;
      if ((res_vld && prod_cnt_ff < 4'(MaxResults)) || state_ff == ST_FLUSH) begin
         rsp_kind <= pend_ff.kind;
         rsp_out_handle <= pend_ff.handle;
         rsp_ack_number <= pend_ff.ack_number;
         rsp_ack_flags <= pend_ff.ack_flags;
         rsp_ack_window <= pend_ff.ack_window;
         rsp_peer_ip <= pend_ff.peer_ip;
         rsp_peer_port <= pend_ff.peer_port;
         rsp_peer_mac <= pend_ff.peer_mac;
         rsp_last <= (state_ff == ST_FLUSH);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= '{eth_type: req_eth_type, ip_protocol: req_ip_protocol,
                     source_ip: req_source_ip, source_port: req_source_port,
                     dest_port: req_dest_port, source_mac: req_source_mac,
                     seq_number: req_seq_number, header_flags: req_header_flags,
                     payload_length: req_payload_length,
                     buffer_handle: req_buffer_handle};
      end
      case (state_ff)
         ST_CHK: begin
            ci_ff <= '0;
            found_ff <= 1'b0;
            freef_ff <= 1'b0;
         end
         ST_CEV: begin
            if (conn_vld_ff[ci_ff]) begin
               if (!found_ff && conn_hit) begin
                  found_ff <= 1'b1;
                  c_ff <= ci_ff;
               end
            end else if (!freef_ff) begin
               freef_ff <= 1'b1;
               free_ff <= ci_ff;
            end
            ci_ff <= ci_ff + CW'(1);
         end
         ST_CNEW: begin
            base_ff <= base_calc;
            open_ff <= 1'b1;
            if (!found_ff) begin
               c_ff <= free_ff;
               cip_ff <= req_ff.source_ip;
               cport_ff <= req_ff.source_port;
               cmac_ff <= req_ff.source_mac;
               exp_ff <= '0;
               last_ff <= '0;
            end
         end
         ST_CLOAD: begin
            cip_ff <= conn_q_ff.ip;
            cport_ff <= conn_q_ff.port;
            cmac_ff <= conn_open_ff[c_ff] ? conn_q_ff.mac : req_ff.source_mac;
            exp_ff <= conn_q_ff.expected;
            last_ff <= conn_q_ff.last_acked;
         end
         ST_DISP: begin
            k_ff <= '0;
            have_min_ff <= 1'b0;
            have_thr_ff <= 1'b0;
            same_f_ff <= 1'b0;
            empty_f_ff <= 1'b0;
            mode_fin_ff <= !is_syn && is_fin;
            if (is_syn) begin
               exp_ff <= alu.sum;
               last_ff <= req_ff.seq_number;
            end else if (is_fin) begin
               open_ff <= 1'b0;
            end
         end
         ST_DADD, ST_PADD: begin
            exp_ff <= alu.sum;
            last_ff <= alu.sum;
         end
         ST_SCMP1: if (!(slot_cur_vld && (!have_thr_ff || alu.lt))) k_ff <= k_ff + RW'(1);
         ST_SCMP2: begin
            if (!have_min_ff || alu.lt) begin
               have_min_ff <= 1'b1;
               min_ff <= slot_q_ff.seq;
               min_k_ff <= k_ff;
            end
            k_ff <= k_ff + RW'(1);
         end
         ST_SDONE: begin
            k_ff <= min_k_ff;
            thr_ff <= min_ff;
            have_thr_ff <= 1'b1;
         end
         ST_PROC: begin
            k_ff <= '0;
            have_min_ff <= 1'b0;
         end
         ST_HEV: begin
            if (slot_cur_vld) begin
               if (!same_f_ff && alu.eq) begin
                  same_f_ff <= 1'b1;
                  same_k_ff <= k_ff;
               end
            end else if (!empty_f_ff) begin
               empty_f_ff <= 1'b1;
               empty_k_ff <= k_ff;
            end
            k_ff <= k_ff + RW'(1);
         end
         ST_HDONE: k_ff <= same_k_ff;
         default: begin
         end
      endcase
   end
endmodule
